// ===== hw/rtl/tle_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tle_pkg
// Character codes, key codes and mode encoding for the terminal line editor.
// ---------------------------------------------------------------------------
package tle_pkg;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESC2   = 2'd1,
    MODE_ESC3   = 2'd2
  } mode_t;

  localparam logic [7:0] CH_PROMPT   = 8'h3E;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_SP       = 8'h20;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7F;

  localparam logic [23:0] KEY_F1   = 24'h1B4F50;
  localparam logic [23:0] KEY_F3   = 24'h1B4F52;
  localparam logic [23:0] KEY_UP   = 24'h1B5B41;
  localparam logic [23:0] KEY_DOWN = 24'h1B5B42;

  localparam logic [15:0] ESC_TIMEOUT_RESET = 16'd500;

endpackage

// ===== hw/rtl/terminal_line_editor_with_history.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// terminal_line_editor_with_history
// Serial-terminal line editor with escape-key decode and a history ring.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_stall): one transaction is a received byte
// (in_kind = 0) or an idle poll tick (in_kind = 1). Output channel
// (out_valid/out_stall): echo bytes (out_to_parser = 0) and bytes of a
// completed command line (out_to_parser = 1); out_last marks the final byte
// caused by one input transaction. An input that causes nothing emits nothing.
// cfg_wr_en/cfg_wr_data write the escape timeout (idle ticks), reset 500.
// A small sequencer handles one input at a time; in_stall stays high until
// every result of that input is in the output register. The next input can
// be taken in the first cycle in which in_stall is low. One result is
// held back internally so the last flag is known, so output lags the
// sequencer by one byte.
// After reset a prompt is due, history is empty, the timeout is 500; no
// clearing pass is needed. A stalled receiver freezes the output register
// and the sequencer waits on it, adding the stall cycles.
// ---------------------------------------------------------------------------
module terminal_line_editor_with_history #(
  parameter int LINE_MAX   = 15,
  parameter int HIST_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_to_parser,
  output logic        out_last,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  import tle_pkg::*;

  localparam int LEN_W   = $clog2(LINE_MAX + 1);
  localparam int SLOT_W  = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int CNT_W   = $clog2(HIST_DEPTH + 1);
  localparam int HMEM_D  = HIST_DEPTH * LINE_MAX;
  localparam int HADDR_W = (HMEM_D > 1) ? $clog2(HMEM_D) : 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PROMPT,
    S_DECODE,
    S_CHAR,
    S_ERASE,
    S_CRLF,
    S_SAVE,
    S_FKEY_RD,
    S_FKEY_EMIT,
    S_RECALL_START,
    S_RECALL_RD,
    S_RECALL_EMIT,
    S_FINISH
  } state_t;

  state_t              state_r, state_nxt;
  mode_t               mode_r, mode_nxt;
  logic                prompt_r, prompt_nxt;
  logic [LEN_W-1:0]    line_len_r, line_len_nxt;
  logic [15:0]         esc_cnt_r, esc_cnt_nxt;
  logic [7:0]          esc2_r, esc2_nxt;
  logic [15:0]         timeout_r;
  logic [SLOT_W-1:0]   wslot_r, wslot_nxt;
  logic [SLOT_W-1:0]   cursor_r, cursor_nxt;
  logic [CNT_W-1:0]    hcount_r, hcount_nxt;
  logic [LEN_W-1:0]    hist_len_r [HIST_DEPTH];

  logic                tick_r, tick_nxt;
  logic [7:0]          byte_r, byte_nxt;
  logic [LEN_W-1:0]    idx_r, idx_nxt;
  logic [LEN_W-1:0]    ecnt_r, ecnt_nxt;
  logic [1:0]          phase_r, phase_nxt;
  logic                rec_r, rec_nxt;
  logic                up_r, up_nxt;
  logic                f1_r, f1_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [LEN_W-1:0]    hlen_r, hlen_nxt;
  logic [HADDR_W-1:0]  haddr_r, haddr_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_byte_r, out_byte_nxt;
  logic                out_par_r, out_par_nxt;
  logic                out_last_r, out_last_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic [7:0]          pend_byte_r, pend_byte_nxt;
  logic                pend_par_r, pend_par_nxt;

  logic [7:0]          line_mem [LINE_MAX];
  logic [7:0]          hist_mem [HMEM_D];
  logic [7:0]          hist_rdata_r;

  // datapath control
  logic                emit_en, flush_en;
  logic [7:0]          emit_byte;
  logic                emit_par;
  logic                line_we;
  logic [LEN_W-1:0]    line_waddr;
  logic [7:0]          line_wdata;
  logic                hist_we;
  logic                hlen_we;

  logic                slot_free, can_emit, timed_out;
  logic [SLOT_W-1:0]   cur_slot, wr_slot;
  logic [CNT_W-1:0]    top;
  logic [SLOT_W-1:0]   cursor_moved;
  logic [23:0]         key_code;
  logic [7:0]          line_rd;

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_to_parser = out_par_r;
  assign out_last      = out_last_r;

  assign slot_free = !out_valid_r || !out_stall;
  assign can_emit  = !pend_v_r || slot_free;
  assign timed_out = (esc_cnt_r >= timeout_r);
  assign key_code  = {CH_ESC, esc2_r, byte_r};
  assign line_rd   = line_mem[idx_r];

  assign cur_slot = ({1'b0, cursor_r} < (SLOT_W + 1)'(HIST_DEPTH)) ? cursor_r : '0;
  assign wr_slot  = ({1'b0, wslot_r} < (SLOT_W + 1)'(HIST_DEPTH)) ? wslot_r : '0;
  assign top      = hcount_r - CNT_W'(1);

  // cursor after a recall from slot_r
  always_comb begin
    if (up_r) begin
      cursor_moved = (slot_r == '0) ? SLOT_W'(top) : slot_r - SLOT_W'(1);
    end else begin
      cursor_moved = (CNT_W'(slot_r) >= top) ? '0 : slot_r + SLOT_W'(1);
    end
  end

  function automatic logic [HADDR_W-1:0] slot_base(input logic [SLOT_W-1:0] s);
    slot_base = HADDR_W'(s) * HADDR_W'(LINE_MAX);
  endfunction

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    prompt_nxt = prompt_r;
    line_len_nxt = line_len_r;
    esc_cnt_nxt  = esc_cnt_r;
    esc2_nxt     = esc2_r;
    wslot_nxt    = wslot_r;
    cursor_nxt   = cursor_r;
    hcount_nxt   = hcount_r;
    tick_nxt     = tick_r;
    byte_nxt     = byte_r;
    idx_nxt      = idx_r;
    ecnt_nxt     = ecnt_r;
    phase_nxt    = phase_r;
    rec_nxt      = rec_r;
    up_nxt       = up_r;
    f1_nxt       = f1_r;
    slot_nxt     = slot_r;
    hlen_nxt     = hlen_r;
    haddr_nxt    = haddr_r;

    emit_en    = 1'b0;
    flush_en   = 1'b0;
    emit_byte  = byte_r;
    emit_par   = 1'b0;
    line_we    = 1'b0;
    line_waddr = line_len_r;
    line_wdata = byte_r;
    hist_we    = 1'b0;
    hlen_we    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          tick_nxt  = in_kind;
          byte_nxt  = in_rx_byte;
          state_nxt = S_PROMPT;
        end
      end

      S_PROMPT: begin
        if (!prompt_r) begin
          state_nxt = S_DECODE;
        end else if (can_emit) begin
          emit_en      = 1'b1;
          emit_byte    = CH_PROMPT;
          prompt_nxt   = 1'b0;
          line_len_nxt = '0;
          state_nxt    = S_DECODE;
        end
      end

      S_DECODE: begin
        state_nxt = S_FINISH;
        if (mode_r == MODE_NORMAL || timed_out) begin
          if (mode_r != MODE_NORMAL) begin
            mode_nxt    = MODE_NORMAL;
            esc_cnt_nxt = '0;
          end
          if (!tick_r) begin
            if (byte_r == CH_BS) begin
              if (line_len_r != '0) begin
                line_len_nxt = line_len_r - LEN_W'(1);
                ecnt_nxt     = LEN_W'(1);
                phase_nxt    = '0;
                rec_nxt      = 1'b0;
                state_nxt    = S_ERASE;
              end
            end else if (byte_r == CH_CR) begin
              phase_nxt = '0;
              state_nxt = S_CRLF;
            end else if (byte_r >= CH_PRINT_LO && byte_r <= CH_PRINT_HI) begin
              if (line_len_r < LEN_W'(LINE_MAX)) begin
                state_nxt = S_CHAR;
              end
            end else if (byte_r == CH_ESC) begin
              mode_nxt    = MODE_ESC2;
              esc_cnt_nxt = '0;
            end
          end
        end else if (tick_r) begin
          esc_cnt_nxt = esc_cnt_r + 16'd1;
        end else if (mode_r == MODE_ESC2) begin
          esc2_nxt    = byte_r;
          esc_cnt_nxt = '0;
          mode_nxt    = MODE_ESC3;
        end else begin
          esc_cnt_nxt = '0;
          mode_nxt    = MODE_NORMAL;
          if (key_code == KEY_F1 || key_code == KEY_F3) begin
            if (line_len_r < hist_len_r[cur_slot]) begin
              hlen_nxt  = hist_len_r[cur_slot];
              haddr_nxt = slot_base(cur_slot) + HADDR_W'(line_len_r);
              f1_nxt    = (key_code == KEY_F1);
              state_nxt = S_FKEY_RD;
            end
          end else if (key_code == KEY_UP || key_code == KEY_DOWN) begin
            if (hcount_r != '0) begin
              slot_nxt  = cur_slot;
              hlen_nxt  = hist_len_r[cur_slot];
              up_nxt    = (key_code == KEY_UP);
              rec_nxt   = 1'b1;
              ecnt_nxt  = line_len_r;
              phase_nxt = '0;
              state_nxt = (line_len_r != '0) ? S_ERASE : S_RECALL_START;
            end
          end
        end
      end

      S_CHAR: begin
        if (can_emit) begin
          emit_en      = 1'b1;
          line_we      = 1'b1;
          line_len_nxt = line_len_r + LEN_W'(1);
          state_nxt    = S_FINISH;
        end
      end

      // BS SP BS per character
      S_ERASE: begin
        if (can_emit) begin
          emit_en   = 1'b1;
          emit_byte = (phase_r == 2'd1) ? CH_SP : CH_BS;
          if (phase_r == 2'd2) begin
            phase_nxt = '0;
            ecnt_nxt  = ecnt_r - LEN_W'(1);
            if (ecnt_r == LEN_W'(1)) begin
              state_nxt = rec_r ? S_RECALL_START : S_FINISH;
            end
          end else begin
            phase_nxt = phase_r + 2'd1;
          end
        end
      end

      S_CRLF: begin
        if (can_emit) begin
          emit_en = 1'b1;
          if (phase_r == '0) begin
            emit_byte = CH_CR;
            phase_nxt = 2'd1;
          end else begin
            emit_byte = CH_LF;
            if (line_len_r != '0) begin
              slot_nxt  = wr_slot;
              haddr_nxt = slot_base(wr_slot);
              idx_nxt   = '0;
              state_nxt = S_SAVE;
            end else begin
              prompt_nxt = 1'b1;
              state_nxt  = S_FINISH;
            end
          end
        end
      end

      // copy line into history while delivering it
      S_SAVE: begin
        if (can_emit) begin
          emit_en   = 1'b1;
          emit_byte = line_rd;
          emit_par  = 1'b1;
          hist_we   = 1'b1;
          idx_nxt   = idx_r + LEN_W'(1);
          haddr_nxt = haddr_r + HADDR_W'(1);
          if ((idx_r + LEN_W'(1)) == line_len_r) begin
            hlen_we    = 1'b1;
            cursor_nxt = slot_r;
            if (hcount_r < CNT_W'(HIST_DEPTH)) begin
              hcount_nxt = hcount_r + CNT_W'(1);
            end
            if ((CNT_W'(slot_r) + CNT_W'(1)) >= CNT_W'(HIST_DEPTH)) begin
              wslot_nxt = '0;
            end else begin
              wslot_nxt = slot_r + SLOT_W'(1);
            end
            prompt_nxt = 1'b1;
            state_nxt  = S_FINISH;
          end
        end
      end

      S_FKEY_RD: begin
        state_nxt = S_FKEY_EMIT;
      end

      S_FKEY_EMIT: begin
        if (can_emit) begin
          emit_en      = 1'b1;
          emit_byte    = hist_rdata_r;
          line_we      = 1'b1;
          line_wdata   = hist_rdata_r;
          line_len_nxt = line_len_r + LEN_W'(1);
          haddr_nxt    = haddr_r + HADDR_W'(1);
          if (!f1_r && (line_len_r + LEN_W'(1)) < hlen_r) begin
            state_nxt = S_FKEY_RD;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end

      S_RECALL_START: begin
        idx_nxt   = '0;
        haddr_nxt = slot_base(slot_r);
        if (hlen_r != '0) begin
          state_nxt = S_RECALL_RD;
        end else begin
          line_len_nxt = '0;
          cursor_nxt   = cursor_moved;
          state_nxt    = S_FINISH;
        end
      end

      S_RECALL_RD: begin
        state_nxt = S_RECALL_EMIT;
      end

      S_RECALL_EMIT: begin
        if (can_emit) begin
          emit_en    = 1'b1;
          emit_byte  = hist_rdata_r;
          line_we    = 1'b1;
          line_waddr = idx_r;
          line_wdata = hist_rdata_r;
          idx_nxt    = idx_r + LEN_W'(1);
          haddr_nxt  = haddr_r + HADDR_W'(1);
          if ((idx_r + LEN_W'(1)) < hlen_r) begin
            state_nxt = S_RECALL_RD;
          end else begin
            line_len_nxt = hlen_r;
            cursor_nxt   = cursor_moved;
            state_nxt    = S_FINISH;
          end
        end
      end

      // release the held-back result with last set
      S_FINISH: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (slot_free) begin
          flush_en  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register and one-deep hold-back stage
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_par_nxt   = out_par_r;
    out_last_nxt  = out_last_r;
    pend_v_nxt    = pend_v_r;
    pend_byte_nxt = pend_byte_r;
    pend_par_nxt  = pend_par_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (emit_en) begin
      if (pend_v_r) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = pend_byte_r;
        out_par_nxt   = pend_par_r;
        out_last_nxt  = 1'b0;
      end
      pend_v_nxt    = 1'b1;
      pend_byte_nxt = emit_byte;
      pend_par_nxt  = emit_par;
    end else if (flush_en) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = pend_byte_r;
      out_par_nxt   = pend_par_r;
      out_last_nxt  = 1'b1;
      pend_v_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_NORMAL;
      prompt_r    <= 1'b1;
      line_len_r  <= '0;
      esc_cnt_r   <= '0;
      esc2_r      <= '0;
      timeout_r   <= ESC_TIMEOUT_RESET;
      wslot_r     <= '0;
      cursor_r    <= '0;
      hcount_r    <= '0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_len_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      prompt_r    <= prompt_nxt;
      line_len_r  <= line_len_nxt;
      esc_cnt_r   <= esc_cnt_nxt;
      esc2_r      <= esc2_nxt;
      wslot_r     <= wslot_nxt;
      cursor_r    <= cursor_nxt;
      hcount_r    <= hcount_nxt;
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      if (hlen_we) begin
        hist_len_r[slot_r] <= line_len_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    tick_r      <= tick_nxt;
    byte_r      <= byte_nxt;
    idx_r       <= idx_nxt;
    ecnt_r      <= ecnt_nxt;
    phase_r     <= phase_nxt;
    rec_r       <= rec_nxt;
    up_r        <= up_nxt;
    f1_r        <= f1_nxt;
    slot_r      <= slot_nxt;
    hlen_r      <= hlen_nxt;
    haddr_r     <= haddr_nxt;
    out_byte_r  <= out_byte_nxt;
    out_par_r   <= out_par_nxt;
    out_last_r  <= out_last_nxt;
    pend_byte_r <= pend_byte_nxt;
    pend_par_r  <= pend_par_nxt;
  end

  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[line_waddr] <= line_wdata;
    end
  end

  // history memory: one write port, registered read at haddr_r
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[haddr_r] <= line_rd;
    end
    hist_rdata_r <= hist_mem[haddr_r];
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the terminal line editor. A short directed table
// walks prompt, echo, backspace, Enter, history keys, unknown escape codes
// and the escape timeout. Random phases then type lines, recall history and
// mix in broken escape codes and noise, each phase under its own timeout.
// A behavioral copy of the editor predicts every output byte.
// Both handshakes idle and stall at random.
// ---------------------------------------------------------------------------
module tb_top;
  import tle_pkg::*;

  localparam int LINE_MAX     = 15;
  localparam int HIST_DEPTH   = 4;
  localparam int DRAIN_CYCLES = 100;
  localparam int PHASE_ITEMS  = 89;
  localparam int SIDE_SEND    = 0;
  localparam int SIDE_RECV    = 1;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;
  localparam logic [23:0] NO_BYTES = 24'h000000;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_op_t;

  // by_hand rows carry their expected echo bytes; the rest use the predictor
  typedef struct packed {
    row_op_t     op;
    logic        kind;
    logic [15:0] val;
    logic        by_hand;
    logic [1:0]  n_typed;
    logic [23:0] typed;
  } row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       to_parser;
    logic       last;
  } echo_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx;
  } stim_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_kind = 1'b0;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_to_parser;
  logic        out_last;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'h0000;

  terminal_line_editor_with_history #(
    .LINE_MAX  (LINE_MAX),
    .HIST_DEPTH(HIST_DEPTH)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_to_parser(out_to_parser),
    .out_last     (out_last),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // editor state as seen by the predictor
  logic [15:0] esc_limit = ESC_TIMEOUT_RESET;
  mode_t       ed_mode = MODE_NORMAL;
  logic        prompt_due = 1'b1;
  logic [7:0]  line_buf [LINE_MAX];
  int          line_len = 0;
  logic [15:0] esc_wait = 16'h0000;
  logic [7:0]  esc_byte2 = 8'h00;
  logic [7:0]  hist_buf [HIST_DEPTH][LINE_MAX];
  int          hist_len [HIST_DEPTH] = '{default: 0};
  int          hist_wr = 0;
  int          hist_cur = 0;
  int          hist_cnt = 0;

  echo_t item_bytes [$];
  echo_t bytes_due [$];
  stim_t burst_q [$];
  int    calm_left [2] = '{default: 0};
  int    live_items = 0;
  int    mismatches = 0;
  int    stall_left = 0;

  function void put_byte(input logic [7:0] b, input logic p);
    item_bytes.push_back(echo_t'{data: b, to_parser: p, last: 1'b0});
  endfunction

  function void erase_one();
    put_byte(CH_BS, 1'b0);
    put_byte(CH_SP, 1'b0);
    put_byte(CH_BS, 1'b0);
  endfunction

  function void plain_byte(input logic [7:0] b);
    if (b == CH_BS) begin
      if (line_len != 0) begin
        line_len--;
        erase_one();
      end
    end else if (b == CH_CR) begin
      put_byte(CH_CR, 1'b0);
      put_byte(CH_LF, 1'b0);
      if (line_len != 0) begin
        for (int i = 0; i < line_len; i++) hist_buf[hist_wr][i] = line_buf[i];
        hist_len[hist_wr] = line_len;
        if (hist_cnt < HIST_DEPTH) hist_cnt++;
        hist_cur = hist_wr;
        hist_wr = (hist_wr + 1 >= HIST_DEPTH) ? 0 : hist_wr + 1;
        for (int i = 0; i < line_len; i++) put_byte(line_buf[i], 1'b1);
      end
      prompt_due = 1'b1;
    end else if (b >= CH_PRINT_LO && b <= CH_PRINT_HI) begin
      if (line_len < LINE_MAX) begin
        line_buf[line_len] = b;
        line_len++;
        put_byte(b, 1'b0);
      end
    end else if (b == CH_ESC) begin
      ed_mode = MODE_ESC2;
      esc_wait = 16'h0000;
    end
  endfunction

  function void edit_predict(input logic kind, input logic [7:0] rx);
    logic [23:0] code;
    int s, top;
    echo_t tail;
    item_bytes.delete();
    if (prompt_due) begin
      prompt_due = 1'b0;
      line_len = 0;
      put_byte(CH_PROMPT, 1'b0);
    end
    if (ed_mode == MODE_NORMAL) begin
      if (kind == KIND_BYTE) plain_byte(rx);
    end else if (esc_wait >= esc_limit) begin
      // timed out: a plain Esc, then the byte is an ordinary one
      ed_mode = MODE_NORMAL;
      esc_wait = 16'h0000;
      if (kind == KIND_BYTE) plain_byte(rx);
    end else if (kind == KIND_TICK) begin
      esc_wait = esc_wait + 16'd1;
    end else if (ed_mode == MODE_ESC2) begin
      esc_byte2 = rx;
      esc_wait = 16'h0000;
      ed_mode = MODE_ESC3;
    end else begin
      code = {CH_ESC, esc_byte2, rx};
      esc_wait = 16'h0000;
      ed_mode = MODE_NORMAL;
      s = hist_cur;
      if (code == KEY_F1 || code == KEY_F3) begin
        while (line_len < hist_len[s]) begin
          line_buf[line_len] = hist_buf[s][line_len];
          put_byte(line_buf[line_len], 1'b0);
          line_len++;
          if (code == KEY_F1) break;
        end
      end else if ((code == KEY_UP || code == KEY_DOWN) && hist_cnt != 0) begin
        repeat (line_len) erase_one();
        for (int i = 0; i < hist_len[s]; i++) begin
          line_buf[i] = hist_buf[s][i];
          put_byte(line_buf[i], 1'b0);
        end
        line_len = hist_len[s];
        top = hist_cnt - 1;
        if (code == KEY_UP) hist_cur = (s == 0) ? top : s - 1;
        else hist_cur = (s >= top) ? 0 : s + 1;
      end
    end
    if (item_bytes.size() != 0) begin
      tail = item_bytes.pop_back();
      tail.last = 1'b1;
      item_bytes.push_back(tail);
    end
  endfunction

  // wait cycles per transaction, with calm stretches of no waiting
  function int draw_wait(input int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm_left[side] = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  // idle ticks inside an escape code; with short limits some run past it
  function void queue_esc_ticks();
    int n;
    n = (esc_limit < 16'd8) ? $urandom_range(0, esc_limit + 1) : $urandom_range(0, 2);
    repeat (n) burst_q.push_back(stim_t'{kind: KIND_TICK, rx: 8'($urandom_range(0, 255))});
  endfunction

  task report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 50) $display("ERROR @%0t ns: %s", $time, msg);
  endtask

  task check_result();
    echo_t want;
    if (bytes_due.size() == 0) begin
      report_mismatch($sformatf("unexpected result byte %02h to_parser %0b last %0b",
                                out_byte, out_to_parser, out_last));
    end else begin
      want = bytes_due.pop_front();
      if (out_byte !== want.data)
        report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, want.data));
      if (out_to_parser !== want.to_parser)
        report_mismatch($sformatf("out_to_parser %0b, expected %0b (byte %02h)",
                                  out_to_parser, want.to_parser, want.data));
      if (out_last !== want.last)
        report_mismatch($sformatf("out_last %0b, expected %0b (byte %02h)",
                                  out_last, want.last, want.data));
    end
  endtask

  always @(posedge clk) begin : result_side
    int n;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      check_result();
      n = draw_wait(SIDE_RECV);
      out_stall <= (n != 0);
      stall_left <= n;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= 0;
      out_stall <= 1'b0;
    end
  end

  task automatic send_item(input logic kind, input logic [7:0] rx, input logic by_hand,
                           input int n_typed, input logic [23:0] typed);
    int gap;
    gap = draw_wait(SIDE_SEND);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_rx_byte <= rx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // transaction taken at this edge
    edit_predict(kind, rx);
    live_items++;
    if (by_hand) begin
      for (int i = 0; i < n_typed; i++)
        bytes_due.push_back(echo_t'{data: typed[23 - 8 * i -: 8], to_parser: 1'b0,
                                    last: (i == n_typed - 1)});
    end else begin
      foreach (item_bytes[i]) bytes_due.push_back(item_bytes[i]);
    end
  endtask

  task settle_idle();
    in_valid <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task write_timeout(input logic [15:0] polls);
    settle_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= polls;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    esc_limit = polls;
  endtask

  initial begin : stimulus
    row_t        plan [27];
    logic [15:0] limits [5];
    logic [23:0] key;
    stim_t       one;
    logic        paused;
    int          pick;

    plan = '{
      '{ROW_ITEM, KIND_TICK, 16'h00FF,            1'b1, 2'd1, {CH_PROMPT, 16'h0000}},
      '{ROW_ITEM, KIND_BYTE, {8'h00, CH_ESC},     1'b1, 2'd0, NO_BYTES},
      '{ROW_ITEM, KIND_BYTE, {8'h00, KEY_UP[15:8]}, 1'b1, 2'd0, NO_BYTES},
      '{ROW_ITEM, KIND_BYTE, {8'h00, KEY_UP[7:0]},  1'b1, 2'd0, NO_BYTES},
      '{ROW_ITEM, KIND_BYTE, {8'h00, CH_PRINT_LO}, 1'b1, 2'd1, {CH_PRINT_LO, 16'h0000}},
      '{ROW_ITEM, KIND_BYTE, {8'h00, CH_PRINT_HI}, 1'b1, 2'd1, {CH_PRINT_HI, 16'h0000}},
      '{ROW_ITEM, KIND_BYTE, 16'h0080,            1'b1, 2'd0, NO_BYTES},
      '{ROW_ITEM, KIND_BYTE, {8'h00, CH_BS},      1'b1, 2'd3, {CH_BS, CH_SP, CH_BS}},
      '{ROW_ITEM, KIND_BYTE, {8'h00, CH_BS},      1'b1, 2'd3, {CH_BS, CH_SP, CH_BS}},
      '{ROW_ITEM, KIND_BYTE, {8'h00, CH_BS},      1'b1, 2'd0, NO_BYTES},
      '{ROW_ITEM, KIND_BYTE, {8'h00, CH_CR},      1'b1, 2'd2, {CH_CR, CH_LF, 8'h00}},
      '{ROW_ITEM, KIND_BYTE, 16'h0061,            1'b1, 2'd2, {CH_PROMPT, 8'h61, 8'h00}},
      '{ROW_ITEM, KIND_BYTE, 16'h0062,            1'b1, 2'd1, {8'h62, 16'h0000}},
      '{ROW_ITEM, KIND_BYTE, {8'h00, CH_CR},      1'b0, 2'd0, NO_BYTES},
      '{ROW_ITEM, KIND_BYTE, {8'h00, CH_ESC},     1'b1, 2'd1, {CH_PROMPT, 16'h0000}},
      '{ROW_ITEM, KIND_BYTE, {8'h00, KEY_F1[15:8]}, 1'b1, 2'd0, NO_BYTES},
      '{ROW_ITEM, KIND_BYTE, {8'h00, KEY_F1[7:0]},  1'b0, 2'd0, NO_BYTES},
      '{ROW_ITEM, KIND_BYTE, {8'h00, CH_ESC},     1'b1, 2'd0, NO_BYTES},
      '{ROW_ITEM, KIND_BYTE, {8'h00, KEY_F3[15:8]}, 1'b1, 2'd0, NO_BYTES},
      '{ROW_ITEM, KIND_BYTE, {8'h00, KEY_F3[7:0]},  1'b0, 2'd0, NO_BYTES},
      '{ROW_ITEM, KIND_BYTE, {8'h00, CH_ESC},     1'b1, 2'd0, NO_BYTES},
      '{ROW_ITEM, KIND_BYTE, 16'h0000,            1'b1, 2'd0, NO_BYTES},
      '{ROW_ITEM, KIND_BYTE, 16'h00FF,            1'b1, 2'd0, NO_BYTES},
      '{ROW_CFG,  KIND_BYTE, 16'd1,               1'b0, 2'd0, NO_BYTES},
      '{ROW_ITEM, KIND_BYTE, {8'h00, CH_ESC},     1'b1, 2'd0, NO_BYTES},
      '{ROW_ITEM, KIND_TICK, 16'h0000,            1'b1, 2'd0, NO_BYTES},
      '{ROW_ITEM, KIND_BYTE, 16'h007A,            1'b1, 2'd1, {8'h7A, 16'h0000}}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < 27; r++) begin
      if (plan[r].op == ROW_CFG) write_timeout(plan[r].val);
      else send_item(plan[r].kind, plan[r].val[7:0], plan[r].by_hand,
                     int'(plan[r].n_typed), plan[r].typed);
    end

    limits = '{16'hFFFF, 16'h0000, 16'd4, 16'd1, 16'd2};
    limits[4] = 16'($urandom_range(2, 12));

    for (int ph = 0; ph < 5; ph++) begin
      write_timeout(limits[ph]);
      live_items = 0;
      paused = 1'b0;
      while (live_items < PHASE_ITEMS) begin
        if (!paused && live_items >= PHASE_ITEMS / 2) begin
          settle_idle();
          paused = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          repeat ($urandom_range(1, 18))
            burst_q.push_back(stim_t'{kind: KIND_BYTE, rx: 8'($urandom_range(32, 127))});
        end else if (pick < 40) begin
          repeat ($urandom_range(1, 4)) burst_q.push_back(stim_t'{kind: KIND_BYTE, rx: CH_BS});
        end else if (pick < 55) begin
          burst_q.push_back(stim_t'{kind: KIND_BYTE, rx: CH_CR});
        end else if (pick < 80) begin
          case ($urandom_range(0, 3))
            0:       key = KEY_F1;
            1:       key = KEY_F3;
            2:       key = KEY_UP;
            default: key = KEY_DOWN;
          endcase
          burst_q.push_back(stim_t'{kind: KIND_BYTE, rx: CH_ESC});
          queue_esc_ticks();
          burst_q.push_back(stim_t'{kind: KIND_BYTE, rx: key[15:8]});
          queue_esc_ticks();
          burst_q.push_back(stim_t'{kind: KIND_BYTE, rx: key[7:0]});
        end else if (pick < 88) begin
          // broken or unknown escape code
          burst_q.push_back(stim_t'{kind: KIND_BYTE, rx: CH_ESC});
          queue_esc_ticks();
          burst_q.push_back(stim_t'{kind: KIND_BYTE, rx: 8'($urandom_range(0, 255))});
          queue_esc_ticks();
          burst_q.push_back(stim_t'{kind: KIND_BYTE, rx: 8'($urandom_range(0, 255))});
        end else if (pick < 94) begin
          repeat ($urandom_range(1, 4))
            burst_q.push_back(stim_t'{kind: KIND_TICK, rx: 8'($urandom_range(0, 255))});
        end else begin
          repeat ($urandom_range(1, 3))
            burst_q.push_back(stim_t'{kind: 1'($urandom_range(0, 1)),
                                      rx: 8'($urandom_range(0, 255))});
        end
        while (burst_q.size() != 0) begin
          one = burst_q.pop_front();
          send_item(one.kind, one.rx, 1'b0, 0, NO_BYTES);
        end
      end
    end

    settle_idle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("ERROR: run did not finish in time");
    $display("Mismatches found");
    $finish;
  end

endmodule
